// File: rtl/core/insertable_array_store_macros.svh
// assertion macros for the insertable array store
// used by insertable_array_store.sv under rtl/core, needs no other file
`ifndef INSERTABLE_ARRAY_STORE_MACROS_SVH
`define INSERTABLE_ARRAY_STORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is held
`define IAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ias assertion failed");
// next-cycle implication, disabled while reset is held
`define IAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ias assertion failed");
`else
`define IAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/ias_pkg.sv
// types and constants shared by the insertable array store
// no dependencies
`timescale 1ns / 1ps

package ias_pkg;

	localparam int WORD_W = 32;
	localparam int POS_W  = 5;
	localparam int CNT_W  = 5;

	// request kinds
	localparam logic [2:0] MODE_APPEND = 3'd0;
	localparam logic [2:0] MODE_INSERT = 3'd1;
	localparam logic [2:0] MODE_READ   = 3'd2;
	localparam logic [2:0] MODE_POP    = 3'd3;
	localparam logic [2:0] MODE_ERASE  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// word returned by a read out of range
	localparam logic signed [WORD_W-1:0] RD_MISS = -32'sd1;

	typedef struct packed {
		logic [2:0]               mode;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_word;
		logic [CNT_W-1:0]         count;
		logic [1:0]               status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_WRVAL,
		S_SHIFT_DN,
		S_RD_WAIT,
		S_RESULT
	} state_t;

endpackage

// File: rtl/core/ias_chan_if.sv
// valid/ready channel carrying one item per handshake
// payload type is supplied by the instantiating code, typically from ias_pkg
`timescale 1ns / 1ps

interface ias_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/core/ias_rsp_reg.sv
// result output register with valid/ready toward the consumer
// depends on ias_pkg and ias_chan_if
`timescale 1ns / 1ps

module ias_rsp_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ias_pkg::rsp_t data,
	output logic          free,
	ias_chan_if.source    rsp
);

	logic          valid_q;
	ias_pkg::rsp_t data_q;

	// slot is free when empty or being drained this cycle
	assign free = !valid_q || rsp.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && free) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload holding register
	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= data;
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.data  = data_q;

endmodule

// File: rtl/core/insertable_array_store.sv
// Ordered word list held in a single-port-write, registered-read RAM of CAPACITY words.
// Append, remove last, refused and unused requests and an insert at the end go straight to
// the result; a read waits for the registered RAM read; an insert moves the entries from
// the last down to the position one place up, then writes the value; an erase moves the
// entries above the position one place down. One item at a time, set by the one-word-per-
// cycle RAM shift loop; next item accepted once the result is loaded into the output register.
// Reset clears the fill count, sequencer and output valid; RAM contents are not cleared.
`timescale 1ns / 1ps
`include "insertable_array_store_macros.svh"

module insertable_array_store #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ias_chan_if.sink   req,
	ias_chan_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > ias_pkg::POS_W) ? CW : ias_pkg::POS_W;

	// list storage
	logic signed [ias_pkg::WORD_W-1:0] mem [CAPACITY];
	logic signed [ias_pkg::WORD_W-1:0] rdata_q;

	ias_pkg::state_t state_q, state_nxt;
	logic [CW-1:0]   fill_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   pos_q;
	logic signed [ias_pkg::WORD_W-1:0] value_q;
	logic signed [ias_pkg::WORD_W-1:0] res_word_q;
	logic [1:0]      res_status_q;

	// control from the output decoder
	logic                              mem_we, mem_re;
	logic [AW-1:0]                     mem_waddr, mem_raddr;
	logic signed [ias_pkg::WORD_W-1:0] mem_wdata;
	logic                              fill_inc, fill_dec;
	logic                              ptr_ld;
	logic [AW-1:0]                     ptr_nxt;
	logic                              res_ld;
	logic signed [ias_pkg::WORD_W-1:0] res_word;
	logic [1:0]                        res_status;
	logic                              out_load, out_free;
	ias_pkg::rsp_t                     out_data;

	// request decode helpers
	logic          acc;
	logic [MW-1:0] p_ext, f_ext, f_last;
	logic [CW-1:0] fill_m1;
	logic [AW-1:0] p_a, last_a, fill_a;
	logic          full;

	assign acc     = req.valid && (state_q == ias_pkg::S_IDLE);
	assign p_ext   = MW'(req.data.position);
	assign f_ext   = MW'(fill_q);
	assign f_last  = f_ext - MW'(1);
	assign fill_m1 = fill_q - CW'(1);
	assign p_a     = p_ext[AW-1:0];
	assign last_a  = fill_m1[AW-1:0];
	assign fill_a  = fill_q[AW-1:0];
	assign full    = (fill_q == CW'(CAPACITY));

	assign req.ready = (state_q == ias_pkg::S_IDLE);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ias_pkg::S_IDLE: begin
				if (req.valid) begin
					state_nxt = ias_pkg::S_RESULT;
					case (req.data.mode)
						ias_pkg::MODE_INSERT: begin
							if (!(p_ext > f_ext) && !full && (p_ext != f_ext)) begin
								state_nxt = ias_pkg::S_SHIFT_UP;
							end
						end
						ias_pkg::MODE_READ: begin
							if (p_ext < f_ext) begin
								state_nxt = ias_pkg::S_RD_WAIT;
							end
						end
						ias_pkg::MODE_ERASE: begin
							if ((p_ext < f_ext) && (p_ext != f_last)) begin
								state_nxt = ias_pkg::S_SHIFT_DN;
							end
						end
						default: ;
					endcase
				end
			end
			ias_pkg::S_SHIFT_UP: begin
				if (ptr_q == pos_q) begin
					state_nxt = ias_pkg::S_WRVAL;
				end
			end
			ias_pkg::S_WRVAL:   state_nxt = ias_pkg::S_RESULT;
			ias_pkg::S_SHIFT_DN: begin
				if (ptr_q == last_a) begin
					state_nxt = ias_pkg::S_RESULT;
				end
			end
			ias_pkg::S_RD_WAIT: state_nxt = ias_pkg::S_RESULT;
			ias_pkg::S_RESULT: begin
				if (out_free) begin
					state_nxt = ias_pkg::S_IDLE;
				end
			end
			default:            state_nxt = ias_pkg::S_IDLE;
		endcase
	end

	// ram, count and result controls
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		fill_inc   = 1'b0;
		fill_dec   = 1'b0;
		ptr_ld     = 1'b0;
		ptr_nxt    = ptr_q;
		res_ld     = 1'b0;
		res_word   = '0;
		res_status = ias_pkg::ST_OK;
		out_load   = 1'b0;
		unique case (state_q)
			ias_pkg::S_IDLE: begin
				if (acc) begin
					res_ld = 1'b1;
					case (req.data.mode)
						ias_pkg::MODE_APPEND: begin
							if (full) begin
								res_status = ias_pkg::ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = fill_a;
								mem_wdata = req.data.value;
								fill_inc  = 1'b1;
							end
						end
						ias_pkg::MODE_INSERT: begin
							if (p_ext > f_ext) begin
								res_status = ias_pkg::ST_RANGE;
							end else if (full) begin
								res_status = ias_pkg::ST_FULL;
							end else if (p_ext == f_ext) begin
								mem_we    = 1'b1;
								mem_waddr = p_a;
								mem_wdata = req.data.value;
								fill_inc  = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = last_a;
								ptr_ld    = 1'b1;
								ptr_nxt   = last_a;
							end
						end
						ias_pkg::MODE_READ: begin
							if (!(p_ext < f_ext)) begin
								res_word   = ias_pkg::RD_MISS;
								res_status = ias_pkg::ST_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = p_a;
							end
						end
						ias_pkg::MODE_POP: begin
							if (fill_q == '0) begin
								res_status = ias_pkg::ST_EMPTY;
							end else begin
								fill_dec = 1'b1;
							end
						end
						ias_pkg::MODE_ERASE: begin
							if (!(p_ext < f_ext)) begin
								res_status = ias_pkg::ST_RANGE;
							end else if (p_ext == f_last) begin
								fill_dec = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = p_a + AW'(1);
								ptr_ld    = 1'b1;
								ptr_nxt   = p_a + AW'(1);
							end
						end
						default: ;
					endcase
				end
			end
			ias_pkg::S_SHIFT_UP: begin
				// move the word read last cycle one place up
				mem_we    = 1'b1;
				mem_waddr = ptr_q + AW'(1);
				mem_wdata = rdata_q;
				if (ptr_q != pos_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q - AW'(1);
					ptr_ld    = 1'b1;
					ptr_nxt   = ptr_q - AW'(1);
				end
			end
			ias_pkg::S_WRVAL: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = value_q;
				fill_inc  = 1'b1;
			end
			ias_pkg::S_SHIFT_DN: begin
				// move the word read last cycle one place down
				mem_we    = 1'b1;
				mem_waddr = ptr_q - AW'(1);
				mem_wdata = rdata_q;
				if (ptr_q != last_a) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + AW'(1);
					ptr_ld    = 1'b1;
					ptr_nxt   = ptr_q + AW'(1);
				end else begin
					fill_dec = 1'b1;
				end
			end
			ias_pkg::S_RD_WAIT: begin
				res_ld   = 1'b1;
				res_word = rdata_q;
			end
			ias_pkg::S_RESULT: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	// state and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ias_pkg::S_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (fill_inc) begin
				fill_q <= fill_q + CW'(1);
			end else if (fill_dec) begin
				fill_q <= fill_m1;
			end
		end
	end

	// request capture, shift pointer and pending result
	always_ff @(posedge clk) begin
		if (acc) begin
			pos_q   <= p_a;
			value_q <= req.data.value;
		end
		if (ptr_ld) begin
			ptr_q <= ptr_nxt;
		end
		if (res_ld) begin
			res_word_q   <= res_word;
			res_status_q <= res_status;
		end
	end

	// ram with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign out_data.read_word = res_word_q;
	assign out_data.count     = f_ext[ias_pkg::CNT_W-1:0];
	assign out_data.status    = res_status_q;

	ias_rsp_reg u_rsp_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.data   (out_data),
		.free   (out_free),
		.rsp    (rsp)
	);

	// checks
	`IAS_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CW'(CAPACITY))
	`IAS_ASSERT_IMP(a_shift_up_window, clk, arst_n, state_q == ias_pkg::S_SHIFT_UP, (ptr_q <= last_a) && (ptr_q >= pos_q))
	`IAS_ASSERT_IMP(a_read_issued, clk, arst_n, state_q == ias_pkg::S_RD_WAIT || state_q == ias_pkg::S_SHIFT_UP || state_q == ias_pkg::S_SHIFT_DN, $past(mem_re))
	`IAS_ASSERT_NXT(a_fill_hold_up, clk, arst_n, state_q == ias_pkg::S_SHIFT_UP, $stable(fill_q))

endmodule
